[hw/rtl/stunp_pkg.sv]
// Package for the STUN message parser: result record, phase codes, attribute codes.
// Used by all modules under hw/rtl; depends on nothing.
package stunp_pkg;

  localparam int IndexBits = 16;
  localparam logic [31:0] MagicCookie = 32'h2112A442;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_ATTR   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_STUN   = 2'd1;
  localparam logic [1:0] ST_SHORT      = 2'd2;
  localparam logic [1:0] ST_BAD_COOKIE = 2'd3;

  localparam logic [15:0] AT_USERNAME    = 16'h0006;
  localparam logic [15:0] AT_INTEGRITY   = 16'h0008;
  localparam logic [15:0] AT_XOR_ADDR    = 16'h0020;
  localparam logic [15:0] AT_PRIORITY    = 16'h0024;
  localparam logic [15:0] AT_USE_CAND    = 16'h0025;
  localparam logic [15:0] AT_SOFTWARE    = 16'h8022;
  localparam logic [15:0] AT_FINGERPRINT = 16'h8028;
  localparam logic [15:0] AT_ICE_CTLD    = 16'h8029;
  localparam logic [15:0] AT_ICE_CTLG    = 16'h802A;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ATTR_HDR, PH_VALUE, PH_PAD, PH_IGNORE
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [15:0] message_type;
    logic [31:0] transaction_upper;
    logic [63:0] transaction_lower;
    logic [15:0] attribute_type;
    logic [15:0] length_field;
    logic [15:0] attribute_offset;
    logic [15:0] attribute_span;
    logic [63:0] attribute_value;
    logic [15:0] mapped_port;
    logic        last_result;
  } result_t;

  function automatic logic [3:0] value_need(input logic [15:0] t);
    if (t == AT_PRIORITY || t == AT_FINGERPRINT) return 4'd4;
    if (t == AT_ICE_CTLD || t == AT_ICE_CTLG || t == AT_XOR_ADDR) return 4'd8;
    return 4'd0;
  endfunction

  function automatic logic type_known(input logic [15:0] t);
    return t == AT_USERNAME || t == AT_INTEGRITY || t == AT_XOR_ADDR ||
           t == AT_PRIORITY || t == AT_USE_CAND || t == AT_SOFTWARE ||
           t == AT_FINGERPRINT || t == AT_ICE_CTLD || t == AT_ICE_CTLG;
  endfunction

endpackage

[hw/rtl/stunp_front.sv]
// Front end: takes one datagram byte per beat, tracks the parse state and
// produces up to two result records per byte. Depends on stunp_pkg.
module stunp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_vld,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic [1:0]          res_cnt,
  output stunp_pkg::result_t  res0,
  output stunp_pkg::result_t  res1
);

  localparam int IB = stunp_pkg::IndexBits;

  logic [IB-1:0]      byte_index_r, byte_index_nxt;
  stunp_pkg::phase_t  phase_r, phase_nxt;
  logic [63:0]        shift_r, shift_nxt;
  logic [31:0]        htl_r, htl_nxt;
  logic [31:0]        thw_r, thw_nxt;
  logic [15:0]        atype_r, atype_nxt;
  logic [15:0]        alen_r, alen_nxt;
  logic [15:0]        aoff_r, aoff_nxt;
  logic [15:0]        vseen_r, vseen_nxt;
  logic [7:0]         fam_r, fam_nxt;
  logic [15:0]        port_r, port_nxt;
  logic [1:0]         pst_r, pst_nxt;

  stunp_pkg::result_t hdr_res, attr_res, stat_res;
  logic               attr_ok;
  logic               emit;
  logic [63:0]        sh;
  logic [15:0]        vs_inc;
  logic [1:0]         st;
  logic [IB-1:0]      bi_after;

  always_comb begin
    byte_index_nxt = byte_index_r;
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    htl_nxt = htl_r;
    thw_nxt = thw_r;
    atype_nxt = atype_r;
    alen_nxt = alen_r;
    aoff_nxt = aoff_r;
    vseen_nxt = vseen_r;
    fam_nxt = fam_r;
    port_nxt = port_r;
    pst_nxt = pst_r;
    hdr_res = '0;
    attr_res = '0;
    attr_ok = 1'b0;
    emit = 1'b0;
    stat_res = '0;
    res_cnt = 2'd0;
    res0 = '0;
    res1 = '0;
    sh = {shift_r[55:0], data_byte};
    vs_inc = vseen_r + 16'd1;
    st = pst_r;
    bi_after = byte_index_r;
    if (byte_vld) begin
      unique case (phase_r)
        stunp_pkg::PH_HEADER: begin
          if (byte_index_r == '0 && data_byte[7:6] != 2'b00) begin
            pst_nxt = stunp_pkg::ST_NOT_STUN;
            phase_nxt = stunp_pkg::PH_IGNORE;
          end else if (byte_index_r < IB'(4)) begin
            htl_nxt = {htl_r[23:0], data_byte};
          end else if (byte_index_r < IB'(8)) begin
            shift_nxt = sh;
            if (byte_index_r == IB'(7)) begin
              if (sh[31:0] != stunp_pkg::MagicCookie) begin
                pst_nxt = stunp_pkg::ST_BAD_COOKIE;
                phase_nxt = stunp_pkg::PH_IGNORE;
              end
              shift_nxt = '0;
            end
          end else if (byte_index_r < IB'(12)) begin
            thw_nxt = {thw_r[23:0], data_byte};
          end else begin
            shift_nxt = sh;
            if (byte_index_r == IB'(19)) begin
              hdr_res.kind = stunp_pkg::KIND_HEADER;
              hdr_res.message_type = htl_r[31:16];
              hdr_res.transaction_upper = thw_r;
              hdr_res.transaction_lower = sh;
              hdr_res.length_field = htl_r[15:0];
              res0 = hdr_res;
              res_cnt = 2'd1;
              phase_nxt = stunp_pkg::PH_ATTR_HDR;
              vseen_nxt = '0;
              shift_nxt = '0;
            end
          end
        end
        stunp_pkg::PH_ATTR_HDR: begin
          if (vseen_r == '0) aoff_nxt = 16'(byte_index_r);
          shift_nxt = sh;
          vseen_nxt = vs_inc;
          if (vs_inc == 16'd4) begin
            atype_nxt = sh[31:16];
            alen_nxt = sh[15:0];
            shift_nxt = '0;
            vseen_nxt = '0;
            fam_nxt = '0;
            port_nxt = '0;
            if (sh[15:0] == 16'd0) begin
              emit = 1'b1;
              phase_nxt = stunp_pkg::PH_ATTR_HDR;
            end else begin
              phase_nxt = stunp_pkg::PH_VALUE;
            end
          end
        end
        stunp_pkg::PH_VALUE: begin
          if (vseen_r < {12'd0, stunp_pkg::value_need(atype_r)}) shift_nxt = sh;
          if (vseen_r == 16'd1) fam_nxt = data_byte;
          if (vseen_r == 16'd2) port_nxt = {data_byte, 8'd0};
          if (vseen_r == 16'd3) port_nxt = {port_r[15:8], data_byte};
          vseen_nxt = vs_inc;
          if (vs_inc == alen_r) begin
            if (vs_inc[1:0] == 2'd0) begin
              emit = 1'b1;
              phase_nxt = stunp_pkg::PH_ATTR_HDR;
            end else begin
              phase_nxt = stunp_pkg::PH_PAD;
            end
          end
        end
        stunp_pkg::PH_PAD: begin
          vseen_nxt = vs_inc;
          if (vs_inc[1:0] == 2'd0) begin
            emit = 1'b1;
            phase_nxt = stunp_pkg::PH_ATTR_HDR;
          end
        end
        default: ;
      endcase
      // build the attribute record before the restart clears the scratch state
      attr_res.kind = stunp_pkg::KIND_ATTR;
      attr_res.attribute_type = atype_nxt;
      attr_res.length_field = alen_nxt;
      attr_res.attribute_offset = aoff_nxt;
      attr_res.attribute_span = 16'd4 + vseen_nxt;
      attr_ok = stunp_pkg::type_known(atype_nxt) &&
                alen_nxt >= {12'd0, stunp_pkg::value_need(atype_nxt)};
      if (atype_nxt == stunp_pkg::AT_XOR_ADDR) begin
        if (fam_nxt != 8'd1) attr_ok = 1'b0;
        attr_res.attribute_value = {32'd0, shift_nxt[31:0] ^ stunp_pkg::MagicCookie};
        attr_res.mapped_port = port_nxt ^ stunp_pkg::MagicCookie[31:16];
      end else if (stunp_pkg::value_need(atype_nxt) != 4'd0) begin
        attr_res.attribute_value = shift_nxt;
      end
      if (emit && attr_ok) begin
        res0 = attr_res;
        res_cnt = 2'd1;
      end
      // attribute restart clears the scratch state after reporting
      if (phase_nxt == stunp_pkg::PH_ATTR_HDR && phase_r != stunp_pkg::PH_ATTR_HDR &&
          phase_r != stunp_pkg::PH_HEADER) begin
        vseen_nxt = '0;
        shift_nxt = '0;
      end
      if (phase_r == stunp_pkg::PH_ATTR_HDR && vs_inc == 16'd4 && sh[15:0] == 16'd0) begin
        vseen_nxt = '0;
        shift_nxt = '0;
      end
      if (byte_index_r != '1) bi_after = byte_index_r + IB'(1);
      byte_index_nxt = bi_after;
      if (last_byte) begin
        if (phase_nxt == stunp_pkg::PH_PAD && attr_ok) begin
          res0 = attr_res;
          res_cnt = 2'd1;
        end
        if (st != stunp_pkg::ST_NOT_STUN && pst_nxt != stunp_pkg::ST_NOT_STUN &&
            phase_nxt == stunp_pkg::PH_HEADER) st = stunp_pkg::ST_SHORT;
        else st = pst_nxt;
        if (st == stunp_pkg::ST_BAD_COOKIE && bi_after < IB'(20)) st = stunp_pkg::ST_SHORT;
        stat_res.kind = stunp_pkg::KIND_STATUS;
        stat_res.status = st;
        stat_res.last_result = 1'b1;
        if (res_cnt == 2'd1) begin
          res1 = stat_res;
          res_cnt = 2'd2;
        end else begin
          res0 = stat_res;
          res_cnt = 2'd1;
        end
        byte_index_nxt = '0;
        phase_nxt = stunp_pkg::PH_HEADER;
        shift_nxt = '0;
        htl_nxt = '0;
        thw_nxt = '0;
        atype_nxt = '0;
        alen_nxt = '0;
        aoff_nxt = '0;
        vseen_nxt = '0;
        fam_nxt = '0;
        port_nxt = '0;
        pst_nxt = stunp_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      phase_r <= stunp_pkg::PH_HEADER;
      shift_r <= '0;
      htl_r <= '0;
      thw_r <= '0;
      atype_r <= '0;
      alen_r <= '0;
      aoff_r <= '0;
      vseen_r <= '0;
      fam_r <= '0;
      port_r <= '0;
      pst_r <= stunp_pkg::ST_OK;
    end else begin
      byte_index_r <= byte_index_nxt;
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      htl_r <= htl_nxt;
      thw_r <= thw_nxt;
      atype_r <= atype_nxt;
      alen_r <= alen_nxt;
      aoff_r <= aoff_nxt;
      vseen_r <= vseen_nxt;
      fam_r <= fam_nxt;
      port_r <= port_nxt;
      pst_r <= pst_nxt;
    end
  end

endmodule

[hw/rtl/stunp_queue.sv]
// Result queue between the parser front end and the output stage: four
// entries, takes up to two records per cycle, gives one. Depends on stunp_pkg.
module stunp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          wr_cnt,
  input  stunp_pkg::result_t  wr0,
  input  stunp_pkg::result_t  wr1,
  output logic                room2,
  output logic                rd_vld,
  output stunp_pkg::result_t  rd_data,
  input  logic                rd_en
);

  stunp_pkg::result_t mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       rd_fire;

  assign rd_vld  = cnt_r != 3'd0;
  assign rd_data = mem_r[rp_r];
  assign room2   = cnt_r <= 3'd2;
  assign rd_fire = rd_en && rd_vld;

  always_comb begin
    wp_nxt = wp_r + wr_cnt;
    rp_nxt = rp_r + {1'b0, rd_fire};
    cnt_nxt = cnt_r + {1'b0, wr_cnt} - {2'b0, rd_fire};
  end

  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) mem_r[wp_r] <= wr0;
    if (wr_cnt == 2'd2) mem_r[wp_r + 2'd1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/stunp_back.sv]
// Output stage: register slice that drives the result stream from the queue.
// Depends on stunp_pkg.
module stunp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_vld,
  input  stunp_pkg::result_t  q_data,
  output logic                q_pop,
  output logic                out_vld,
  output stunp_pkg::result_t  out_data,
  input  logic                out_rdy
);

  logic vld_r, vld_nxt;
  stunp_pkg::result_t data_r;

  assign q_pop    = q_vld && (!vld_r || out_rdy);
  assign out_vld  = vld_r;
  assign out_data = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (out_rdy) vld_nxt = 1'b0;
    if (q_pop) vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (q_pop) data_r <= q_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
  end

endmodule

[hw/rtl/stun_message_parser.sv]
// STUN message parser top level: front end, result queue, output stage.
// Latency: a result passes through the result queue and then the output register before it shows on out_tvalid.
// Throughput: one byte per cycle; the queue takes up to two records per byte and
// drains one per cycle while the output is ready, so a byte is held off only while the queue has < 2 free.
// Reset: rst_n synchronous active low clears parse state, queue and output.
// Depends on stunp_pkg, stunp_front, stunp_queue, stunp_back.
module stun_message_parser (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,   // last_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [263:0] out_tdata,  // status, message_type, transaction_upper,
                                   // transaction_lower, attribute_type, length_field,
                                   // attribute_offset, attribute_span, attribute_value,
                                   // mapped_port (zero fill)
  output logic [1:0]   out_tuser,  // kind
  output logic         out_tlast   // last_result
);

  logic               room2, q_vld, q_pop, b_vld;
  logic [1:0]         res_cnt;
  stunp_pkg::result_t res0, res1, q_data, b_data;

  assign in_tready = room2;

  stunp_front u_front (
    .clk(clk), .rst_n(rst_n), .byte_vld(in_tvalid && room2),
    .data_byte(in_tdata), .last_byte(in_tlast),
    .res_cnt(res_cnt), .res0(res0), .res1(res1)
  );

  stunp_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_cnt(res_cnt), .wr0(res0), .wr1(res1),
    .room2(room2), .rd_vld(q_vld), .rd_data(q_data), .rd_en(q_pop)
  );

  stunp_back u_back (
    .clk(clk), .rst_n(rst_n), .q_vld(q_vld), .q_data(q_data), .q_pop(q_pop),
    .out_vld(b_vld), .out_data(b_data), .out_rdy(out_tready)
  );

  assign out_tvalid = b_vld;
  assign out_tuser  = b_data.kind;
  assign out_tlast  = b_data.last_result;
  assign out_tdata  = {6'd0, b_data.mapped_port, b_data.attribute_value,
                       b_data.attribute_span, b_data.attribute_offset,
                       b_data.length_field, b_data.attribute_type,
                       b_data.transaction_lower, b_data.transaction_upper,
                       b_data.message_type, b_data.status};

endmodule

[hw/rtl/stunp_checker.sv]
// Port checker for the STUN message parser, bound to the top level.
// Depends on stun_message_parser ports and stunp_pkg.
module stunp_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [263:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  ap_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == stunp_pkg::KIND_STATUS)))
    else $error("last flag and kind disagree");

  ap_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= stunp_pkg::KIND_STATUS)
    else $error("bad result kind");

  ap_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or input held off after reset");

  ap_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("input beat withdrawn while stalled");

endmodule

bind stun_message_parser stunp_checker u_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);

[tb/stun_message_parser_tb.sv]
// Self-checking testbench for stun_message_parser: streams datagrams byte by byte and
// checks every header, attribute and status beat against a parser model kept here.
// Depends on stunp_pkg and the stun_message_parser RTL.
module stun_message_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [263:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  stun_message_parser dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  logic [8:0]         byte_beats[$];
  stunp_pkg::result_t parsed_results[$];
  int                 errors = 0;
  int                 cycles = 0;
  bit                 in_taken = 0;
  int                 in_gap = 0;
  int                 out_gap = 0;

  // parser model state
  logic [15:0]       pos;
  stunp_pkg::phase_t ph;
  logic [63:0]       acc;
  logic [31:0]       hdr_tl;
  logic [31:0]       tid_hi;
  logic [15:0]       a_type, a_len, a_off, vseen, port_hold;
  logic [7:0]        fam;
  logic [1:0]        pkt_st;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [15:0] value_bytes_needed(input logic [15:0] t);
    case (t)
      stunp_pkg::AT_PRIORITY, stunp_pkg::AT_FINGERPRINT: return 16'd4;
      stunp_pkg::AT_ICE_CTLD, stunp_pkg::AT_ICE_CTLG, stunp_pkg::AT_XOR_ADDR: return 16'd8;
      default: return 16'd0;
    endcase
  endfunction

  function automatic bit attr_recognised(input logic [15:0] t);
    case (t)
      stunp_pkg::AT_USERNAME, stunp_pkg::AT_INTEGRITY, stunp_pkg::AT_XOR_ADDR,
      stunp_pkg::AT_PRIORITY, stunp_pkg::AT_USE_CAND, stunp_pkg::AT_SOFTWARE,
      stunp_pkg::AT_FINGERPRINT, stunp_pkg::AT_ICE_CTLD, stunp_pkg::AT_ICE_CTLG: return 1;
      default: return 0;
    endcase
  endfunction

  task automatic clear_parser();
    pos = 0; ph = stunp_pkg::PH_HEADER; acc = 0; hdr_tl = 0; tid_hi = 0; a_type = 0;
    a_len = 0; a_off = 0; vseen = 0; fam = 0; port_hold = 0; pkt_st = stunp_pkg::ST_OK;
  endtask

  task automatic next_attribute();
    ph = stunp_pkg::PH_ATTR_HDR; vseen = 0; acc = 0;
  endtask

  task automatic report_attribute();
    stunp_pkg::result_t r;
    r = '0;
    if (!attr_recognised(a_type) || a_len < value_bytes_needed(a_type)) return;
    if (a_type == stunp_pkg::AT_XOR_ADDR) begin
      if (fam != 8'd1) return;
      r.attribute_value = {32'd0, acc[31:0] ^ stunp_pkg::MagicCookie};
      r.mapped_port = port_hold ^ stunp_pkg::MagicCookie[31:16];
    end else if (value_bytes_needed(a_type) != 0) begin
      r.attribute_value = acc;
    end
    r.kind = stunp_pkg::KIND_ATTR;
    r.attribute_type = a_type;
    r.length_field = a_len;
    r.attribute_offset = a_off;
    r.attribute_span = 16'(vseen + 16'd4);
    parsed_results.push_back(r);
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    stunp_pkg::result_t r;
    logic [1:0] st;
    case (ph)
      stunp_pkg::PH_HEADER: begin
        if (pos == 0 && (b & 8'hC0) != 0) begin
          pkt_st = stunp_pkg::ST_NOT_STUN;
          ph = stunp_pkg::PH_IGNORE;
        end else if (pos < 4) begin
          hdr_tl = {hdr_tl[23:0], b};
        end else if (pos < 8) begin
          acc = {acc[55:0], b};
          if (pos == 7) begin
            if (acc[31:0] != stunp_pkg::MagicCookie) begin
              pkt_st = stunp_pkg::ST_BAD_COOKIE;
              ph = stunp_pkg::PH_IGNORE;
            end
            acc = 0;
          end
        end else if (pos < 12) begin
          tid_hi = {tid_hi[23:0], b};
        end else begin
          acc = {acc[55:0], b};
          if (pos == 19) begin
            r = '0;
            r.kind = stunp_pkg::KIND_HEADER;
            r.message_type = hdr_tl[31:16];
            r.transaction_upper = tid_hi;
            r.transaction_lower = acc;
            r.length_field = hdr_tl[15:0];
            parsed_results.push_back(r);
            next_attribute();
          end
        end
      end
      stunp_pkg::PH_ATTR_HDR: begin
        if (vseen == 0) a_off = pos;
        acc = {acc[55:0], b};
        vseen++;
        if (vseen == 4) begin
          a_type = acc[31:16];
          a_len = acc[15:0];
          acc = 0; vseen = 0; fam = 0; port_hold = 0;
          if (a_len == 0) begin
            report_attribute();
            next_attribute();
          end else begin
            ph = stunp_pkg::PH_VALUE;
          end
        end
      end
      stunp_pkg::PH_VALUE: begin
        if (vseen < value_bytes_needed(a_type)) acc = {acc[55:0], b};
        if (vseen == 1) fam = b;
        if (vseen == 2) port_hold = {b, 8'h00};
        if (vseen == 3) port_hold[7:0] = b;
        vseen++;
        if (vseen == a_len) begin
          if (vseen[1:0] == 0) begin
            report_attribute();
            next_attribute();
          end else begin
            ph = stunp_pkg::PH_PAD;
          end
        end
      end
      stunp_pkg::PH_PAD: begin
        vseen++;
        if (vseen[1:0] == 0) begin
          report_attribute();
          next_attribute();
        end
      end
      default: ;
    endcase
    if (pos != 16'hFFFF) pos++;
    if (lst) begin
      st = pkt_st;
      if (ph == stunp_pkg::PH_PAD) report_attribute();
      if (st != stunp_pkg::ST_NOT_STUN && ph == stunp_pkg::PH_HEADER) st = stunp_pkg::ST_SHORT;
      if (st == stunp_pkg::ST_BAD_COOKIE && pos < 20) st = stunp_pkg::ST_SHORT;
      r = '0;
      r.kind = stunp_pkg::KIND_STATUS;
      r.status = st;
      r.last_result = 1;
      parsed_results.push_back(r);
      clear_parser();
    end
  endtask

  // stimulus building
  task automatic put_header(ref logic [7:0] p[$], input bit good_cookie);
    logic [31:0] ck;
    p.push_back(8'($urandom_range(0, 63)));
    repeat (3) p.push_back(8'($urandom));
    ck = good_cookie ? stunp_pkg::MagicCookie :
                       (stunp_pkg::MagicCookie ^ (32'd1 << $urandom_range(0, 31)));
    for (int i = 3; i >= 0; i--) p.push_back(ck[8*i +: 8]);
    repeat (12) p.push_back(8'($urandom));
  endtask

  task automatic put_attr(ref logic [7:0] p[$], input logic [15:0] t, input logic [15:0] len,
                          input logic [7:0] family);
    int total;
    total = (int'(len) + 3) & ~3;
    p.push_back(t[15:8]); p.push_back(t[7:0]);
    p.push_back(len[15:8]); p.push_back(len[7:0]);
    for (int i = 0; i < total; i++)
      p.push_back(i == 1 ? family : (i >= len ? 8'h00 : 8'($urandom)));
  endtask

  task automatic send_datagram(ref logic [7:0] p[$], input int cut);
    int n;
    n = (cut > 0 && cut < p.size()) ? cut : p.size();
    for (int i = 0; i < n; i++) byte_beats.push_back({(i == n - 1) ? 1'b1 : 1'b0, p[i]});
  endtask

  function automatic logic [15:0] pick_type();
    logic [15:0] kinds[10];
    kinds = '{stunp_pkg::AT_USERNAME, stunp_pkg::AT_INTEGRITY, stunp_pkg::AT_XOR_ADDR,
              stunp_pkg::AT_PRIORITY, stunp_pkg::AT_USE_CAND, stunp_pkg::AT_SOFTWARE,
              stunp_pkg::AT_FINGERPRINT, stunp_pkg::AT_ICE_CTLD, stunp_pkg::AT_ICE_CTLG,
              16'h0000};
    pick_type = kinds[$urandom_range(0, 9)];
    if (pick_type == 16'h0000) pick_type = 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_len(input logic [15:0] t);
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 20));
      default: return value_bytes_needed(t) + 16'($urandom_range(0, 2));
    endcase
  endfunction

  initial begin
    logic [7:0] p[$];
    logic [15:0] t;
    rst_n = 0;
    clear_parser();
    // not stun, each top bit, short and long
    p = {8'hC0}; send_datagram(p, 0);
    p = {8'h40, 8'h00, 8'h00, 8'h00}; send_datagram(p, 0);
    p.delete(); put_header(p, 1); p[0] = 8'h80; send_datagram(p, 0);
    // short header, short with a bad cookie, bad cookie at full length
    p.delete(); put_header(p, 1); send_datagram(p, 19);
    p.delete(); put_header(p, 0); send_datagram(p, 12);
    p.delete(); put_header(p, 0); put_attr(p, stunp_pkg::AT_PRIORITY, 4, 8'h01);
    send_datagram(p, 0);
    // extremes of the header fields
    p.delete(); put_header(p, 1);
    p[0] = 8'h3F; p[1] = 8'hFF; p[2] = 8'hFF; p[3] = 8'hFF;
    for (int i = 8; i < 20; i++) p[i] = 8'hFF;
    send_datagram(p, 0);
    p.delete(); put_header(p, 1);
    for (int i = 0; i < 4; i++) p[i] = 8'h00;
    for (int i = 8; i < 20; i++) p[i] = 8'h00;
    send_datagram(p, 0);
    // every known attribute, well formed
    p.delete(); put_header(p, 1);
    put_attr(p, stunp_pkg::AT_USERNAME, 9, 8'h00);
    put_attr(p, stunp_pkg::AT_INTEGRITY, 20, 8'h00);
    put_attr(p, stunp_pkg::AT_XOR_ADDR, 8, 8'h01);
    put_attr(p, stunp_pkg::AT_PRIORITY, 4, 8'h00);
    put_attr(p, stunp_pkg::AT_USE_CAND, 0, 8'h00);
    put_attr(p, stunp_pkg::AT_SOFTWARE, 3, 8'h00);
    put_attr(p, stunp_pkg::AT_FINGERPRINT, 4, 8'h00);
    put_attr(p, stunp_pkg::AT_ICE_CTLD, 8, 8'h00);
    put_attr(p, stunp_pkg::AT_ICE_CTLG, 8, 8'h00);
    send_datagram(p, 0);
    // short values, IPv6, unknown, zero length
    p.delete(); put_header(p, 1);
    put_attr(p, stunp_pkg::AT_PRIORITY, 2, 8'h00);
    put_attr(p, stunp_pkg::AT_ICE_CTLG, 7, 8'h00);
    put_attr(p, stunp_pkg::AT_XOR_ADDR, 20, 8'h02);
    put_attr(p, 16'hFFFF, 5, 8'h00);
    put_attr(p, stunp_pkg::AT_FINGERPRINT, 0, 8'h00);
    put_attr(p, stunp_pkg::AT_XOR_ADDR, 9, 8'h01);
    send_datagram(p, 0);
    // truncated in attribute header, in value, in padding
    p.delete(); put_header(p, 1); put_attr(p, stunp_pkg::AT_PRIORITY, 4, 8'h00);
    send_datagram(p, 22);
    p.delete(); put_header(p, 1); put_attr(p, stunp_pkg::AT_ICE_CTLD, 8, 8'h00);
    send_datagram(p, 29);
    p.delete(); put_header(p, 1); put_attr(p, stunp_pkg::AT_USERNAME, 5, 8'h00);
    send_datagram(p, 30);
    // random part
    while (byte_beats.size() < 550) begin
      p.delete();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 30)) p.push_back(8'($urandom));
        send_datagram(p, 0);
      end else begin
        put_header(p, $urandom_range(0, 9) != 0);
        repeat ($urandom_range(0, 4)) begin
          t = pick_type();
          put_attr(p, t, pick_len(t), ($urandom_range(0, 3) != 0) ? 8'h01 : 8'($urandom));
        end
        send_datagram(p, ($urandom_range(0, 3) == 0) ? $urandom_range(1, p.size()) : 0);
      end
    end
    repeat (12) @(posedge clk);
    rst_n <= 1;
    wait (byte_beats.size() == 0 && !in_tvalid && parsed_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && parsed_results.size() == 0) begin
      $display("[stun_message_parser] OK");
    end else begin
      $display("[stun_message_parser] ERROR");
    end
    $finish;
  end

  // driver
  initial begin
    in_tvalid = 0; in_tdata = 0; in_tlast = 0; out_tready = 0;
  end

  always @(negedge clk) begin
    logic [8:0] beat;
    bit quiet;
    quiet = byte_beats.size() < 60;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_gap <= $urandom_range(0, 5);
        in_tvalid <= 0;
      end else if (byte_beats.size() != 0) begin
        beat = byte_beats.pop_front();
        in_tvalid <= 1;
        in_tdata <= beat[7:0];
        in_tlast <= beat[8];
      end else begin
        in_tvalid <= 0;
      end
    end
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 0;
    end else if (!quiet && $urandom_range(0, 12) == 0) begin
      out_gap <= $urandom_range(0, 5);
      out_tready <= 0;
    end else begin
      out_tready <= 1;
    end
  end

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %h actual %h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    stunp_pkg::result_t want;
    cycles++;
    in_taken <= in_tvalid && in_tready && rst_n;
    if (rst_n && in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      if (parsed_results.size() == 0) begin
        $display("%0t mismatch: expected no beat, actual tuser %h tdata %h",
                 $realtime, out_tuser, out_tdata);
        errors++;
      end else begin
        want = parsed_results.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("status", want.status, out_tdata[1:0]);
        check_field("message_type", want.message_type, out_tdata[17:2]);
        check_field("transaction_upper", want.transaction_upper, out_tdata[49:18]);
        check_field("transaction_lower", want.transaction_lower, out_tdata[113:50]);
        check_field("attribute_type", want.attribute_type, out_tdata[129:114]);
        check_field("length_field", want.length_field, out_tdata[145:130]);
        check_field("attribute_offset", want.attribute_offset, out_tdata[161:146]);
        check_field("attribute_span", want.attribute_span, out_tdata[177:162]);
        check_field("attribute_value", want.attribute_value, out_tdata[241:178]);
        check_field("mapped_port", want.mapped_port, out_tdata[257:242]);
        check_field("zero fill", 64'd0, out_tdata[263:258]);
        check_field("last_result", want.last_result, out_tlast);
      end
    end
    if (cycles > 2000000) begin
      $display("[stun_message_parser] ERROR");
      $finish;
    end
  end

endmodule
